@@ sv/sensor_raw_convert_moving_average_defines.svh @@
// Assertion macros shared by the sensor moving-average block.
`ifndef SENSOR_RAW_CONVERT_MOVING_AVERAGE_DEFINES_SVH
`define SENSOR_RAW_CONVERT_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTH
`define SRCMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SRCMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRCMA_ASSERT_IMP(label, ante, cons, msg)
`define SRCMA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ sv/srcma_pkg.sv @@
// Shared types and constants of the sensor moving-average block.
package srcma_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int RAW_W = 16;
  localparam int MT_W = 15;
  localparam int MH_W = 14;
  localparam int CNT_OUT_W = 5;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;

  localparam int TEMP_SCALE = 17500;
  localparam int HUM_SCALE = 10000;
  localparam int TEMP_OFFSET = 4500;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EST,
    S_CORR,
    S_UPD,
    S_DINIT,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic upd;
    logic dinit;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

@@ sv/srcma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srcma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/srcma_ctrl.sv @@
// Controller state machine of the sensor moving-average block.
module srcma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  srcma_pkg::status_t  status,
  output srcma_pkg::cmd_t     cmd,
  output srcma_pkg::state_t   state
);

  srcma_pkg::state_t state_r;
  srcma_pkg::state_t state_nxt;
  logic              out_tvalid_r;
  logic              out_tvalid_nxt;
  logic              out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srcma_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = srcma_pkg::S_EST;
        end
      end
      srcma_pkg::S_EST:   state_nxt = srcma_pkg::S_CORR;
      srcma_pkg::S_CORR:  state_nxt = srcma_pkg::S_UPD;
      srcma_pkg::S_UPD:   state_nxt = srcma_pkg::S_DINIT;
      srcma_pkg::S_DINIT: state_nxt = srcma_pkg::S_DIV;
      srcma_pkg::S_DIV: begin
        if (status.div_done) begin
          state_nxt = srcma_pkg::S_OUT;
        end
      end
      srcma_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = srcma_pkg::S_IDLE;
        end
      end
      default: state_nxt = srcma_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      srcma_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.accept = in_tvalid;
      end
      srcma_pkg::S_UPD:   cmd.upd = 1'b1;
      srcma_pkg::S_DINIT: cmd.dinit = 1'b1;
      srcma_pkg::S_DIV:   cmd.div_step = 1'b1;
      srcma_pkg::S_OUT:   cmd.load_out = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srcma_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign state = state_r;

endmodule

@@ sv/srcma_dp.sv @@
// Datapath: conversion, sample rings, running sums and mean divider.
module srcma_dp #(
  parameter int DEPTH = srcma_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srcma_pkg::cmd_t                     cmd,
  output srcma_pkg::status_t                  status,
  input  logic [srcma_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic [srcma_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TSUM_W = srcma_pkg::MT_W + CNT_W;
  localparam int HSUM_W = srcma_pkg::MH_W + CNT_W;
  localparam int QW = TSUM_W;
  localparam int DCW = $clog2(QW);
  localparam int PAD_W = srcma_pkg::OUT_DATA_W - srcma_pkg::MT_W - srcma_pkg::MH_W
                         - srcma_pkg::CNT_OUT_W;

  logic [15:0] raw_t;
  logic [15:0] raw_h;
  assign raw_t = in_tdata[15:0];
  assign raw_h = in_tdata[31:16];

  logic [30:0] tprod_r, tprod_nxt;
  logic [29:0] hprod_r, hprod_nxt;
  logic [14:0] tq_r, tq_nxt;
  logic [13:0] hq_r, hq_nxt;
  logic [14:0] tval_r, tval_nxt;
  logic [13:0] hval_r, hval_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TSUM_W-1:0] tsum_r, tsum_nxt;
  logic [HSUM_W-1:0] hsum_r, hsum_nxt;
  logic tneg_r, tneg_nxt;
  logic [QW-1:0] tquo_r, tquo_nxt;
  logic [QW-1:0] hquo_r, hquo_nxt;
  logic [CNT_W-1:0] trem_r, trem_nxt;
  logic [CNT_W-1:0] hrem_r, hrem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [srcma_pkg::OUT_DATA_W-1:0] out_r, out_nxt;

  logic [31:0] test_w;
  logic [30:0] hest_w;
  logic [31:0] tres_w;
  logic [30:0] hres_w;
  logic [14:0] tfix_w;
  logic [13:0] hfix_w;
  logic [15:0] tdiff_w;
  logic [14:0] told_w;
  logic [13:0] hold_w;
  logic        full_w;
  logic [TSUM_W-1:0] tsub_w;
  logic [HSUM_W-1:0] hsub_w;
  logic [TSUM_W-1:0] tmag_w;
  logic [CNT_W:0] ttrial_w;
  logic [CNT_W:0] htrial_w;
  logic [CNT_W:0] dvsr_w;
  logic [QW-1:0] tmean_w;
  logic [CNT_W+4:0] cntx_w;

  srcma_ram #(.WIDTH(srcma_pkg::MT_W), .DEPTH(DEPTH)) u_tram (
    .clk(clk), .we(cmd.upd), .waddr(ptr_r), .wdata(tval_r),
    .re(cmd.accept), .raddr(ptr_r), .rdata(told_w)
  );

  srcma_ram #(.WIDTH(srcma_pkg::MH_W), .DEPTH(DEPTH)) u_hram (
    .clk(clk), .we(cmd.upd), .waddr(ptr_r), .wdata(hval_r),
    .re(cmd.accept), .raddr(ptr_r), .rdata(hold_w)
  );

  // Division by 65535: estimate with one shifted add, then one correction step.
  assign tprod_nxt = {15'b0, raw_t} * 31'(srcma_pkg::TEMP_SCALE);
  assign hprod_nxt = {14'b0, raw_h} * 30'(srcma_pkg::HUM_SCALE);
  assign test_w = {1'b0, tprod_r} + {17'b0, tprod_r[30:16]};
  assign hest_w = {1'b0, hprod_r} + {17'b0, hprod_r[29:16]};
  assign tq_nxt = test_w[30:16];
  assign hq_nxt = hest_w[29:16];
  assign tres_w = {1'b0, tprod_r} - {1'b0, tq_r, 16'b0} + {17'b0, tq_r};
  assign hres_w = {1'b0, hprod_r} - {1'b0, hq_r, 16'b0} + {17'b0, hq_r};
  assign tfix_w = (tres_w >= 32'd65535) ? tq_r + 15'd1 : tq_r;
  assign hfix_w = (hres_w >= 31'd65535) ? hq_r + 14'd1 : hq_r;
  assign tdiff_w = {1'b0, tfix_w} - 16'(srcma_pkg::TEMP_OFFSET);
  assign tval_nxt = tdiff_w[14:0];
  assign hval_nxt = hfix_w;

  assign full_w = (count_r == CNT_W'(DEPTH));
  assign tsub_w = full_w ? {{(TSUM_W-15){told_w[14]}}, told_w} : '0;
  assign hsub_w = full_w ? {{(HSUM_W-14){1'b0}}, hold_w} : '0;
  assign tmag_w = tsum_r[TSUM_W-1] ? (~tsum_r + 1'b1) : tsum_r;
  assign dvsr_w = {1'b0, count_r};
  assign ttrial_w = {trem_r, tquo_r[QW-1]};
  assign htrial_w = {hrem_r, hquo_r[QW-1]};
  assign tmean_w = tneg_r ? (~tquo_r + 1'b1) : tquo_r;
  assign cntx_w = {5'b0, count_r};
  assign status.div_done = (dcnt_r == DCW'(QW - 1));

  always_comb begin
    ptr_nxt = ptr_r;
    count_nxt = count_r;
    tsum_nxt = tsum_r;
    hsum_nxt = hsum_r;
    if (cmd.upd) begin
      ptr_nxt = (ptr_r == PTR_W'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      count_nxt = full_w ? count_r : count_r + 1'b1;
      tsum_nxt = tsum_r + {{(TSUM_W-15){tval_r[14]}}, tval_r} - tsub_w;
      hsum_nxt = hsum_r + {{(HSUM_W-14){1'b0}}, hval_r} - hsub_w;
    end
  end

  always_comb begin
    tneg_nxt = tneg_r;
    tquo_nxt = tquo_r;
    hquo_nxt = hquo_r;
    trem_nxt = trem_r;
    hrem_nxt = hrem_r;
    dcnt_nxt = dcnt_r;
    if (cmd.dinit) begin
      tneg_nxt = tsum_r[TSUM_W-1];
      tquo_nxt = tmag_w;
      hquo_nxt = {{(QW-HSUM_W){1'b0}}, hsum_r};
      trem_nxt = '0;
      hrem_nxt = '0;
      dcnt_nxt = '0;
    end else if (cmd.div_step) begin
      dcnt_nxt = dcnt_r + 1'b1;
      if (ttrial_w >= dvsr_w) begin
        trem_nxt = CNT_W'(ttrial_w - dvsr_w);
        tquo_nxt = {tquo_r[QW-2:0], 1'b1};
      end else begin
        trem_nxt = ttrial_w[CNT_W-1:0];
        tquo_nxt = {tquo_r[QW-2:0], 1'b0};
      end
      if (htrial_w >= dvsr_w) begin
        hrem_nxt = CNT_W'(htrial_w - dvsr_w);
        hquo_nxt = {hquo_r[QW-2:0], 1'b1};
      end else begin
        hrem_nxt = htrial_w[CNT_W-1:0];
        hquo_nxt = {hquo_r[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt = {{PAD_W{1'b0}}, cntx_w[4:0], hquo_r[13:0], tmean_w[14:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      count_r <= '0;
      tsum_r <= '0;
      hsum_r <= '0;
      dcnt_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      count_r <= count_nxt;
      tsum_r <= tsum_nxt;
      hsum_r <= hsum_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tprod_r <= tprod_nxt;
      hprod_r <= hprod_nxt;
    end
    tq_r <= tq_nxt;
    hq_r <= hq_nxt;
    tval_r <= tval_nxt;
    hval_r <= hval_nxt;
    tneg_r <= tneg_nxt;
    tquo_r <= tquo_nxt;
    hquo_r <= hquo_nxt;
    trem_r <= trem_nxt;
    hrem_r <= hrem_nxt;
    out_r <= out_nxt;
  end

  assign out_tdata = out_r;

endmodule

@@ sv/sensor_raw_convert_moving_average.sv @@
// Top level of the sensor raw conversion and moving-average block.
//
//   channel | direction | beat contents
//   in_     | slave     | raw temperature and raw humidity words
//   out_    | master    | mean temperature, mean humidity, samples held
//
// A result is loaded in state OUT after its beat has passed EST, CORR, UPD,
// DINIT and DIV; in DIV the bit-serial mean divider runs over QW bits, where QW
// is the running-sum width (20 bits at DEPTH 16). The next beat is accepted in
// the cycle after the load. The next beat is accepted while a result waits.
// Reset is synchronous and clears the ring position, count and sums.
// A stalled result holds the final load, and with it the next acceptance.
`include "sensor_raw_convert_moving_average_defines.svh"
module sensor_raw_convert_moving_average #(
  parameter int DEPTH = srcma_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // raw_temperature [15:0], raw_humidity [31:16]
  input  logic [srcma_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mean_temperature [14:0], mean_humidity [28:15], samples_held [33:29]
  output logic [srcma_pkg::OUT_DATA_W-1:0] out_tdata
);

  srcma_pkg::cmd_t    cmd;
  srcma_pkg::status_t status;
  srcma_pkg::state_t  state;

  srcma_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .status(status), .cmd(cmd), .state(state)
  );

  srcma_dp #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .status(status),
    .in_tdata(in_tdata), .out_tdata(out_tdata)
  );

  `SRCMA_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `SRCMA_ASSERT_IMP(a_result_from_out, $rose(out_tvalid), $past(state == srcma_pkg::S_OUT), "result without load")

endmodule
